// File: rtl/fkpc_pkg.sv
// Shared types and constants for the four-key short/long press classifier.
`default_nettype none
package fkpc_pkg;

    localparam int NKEYS          = 4;
    localparam int THR_W          = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [THR_W-1:0] SHORT_THR_RST = 16'd2;
    localparam logic [THR_W-1:0] LONG_THR_RST  = 16'd100;
    localparam logic [THR_W-1:0] LIMIT_RST     = 16'd1000;

    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_EVAL  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_THR = 2'd0,
        REG_LONG_THR  = 2'd1,
        REG_LIMIT     = 2'd2,
        REG_UNUSED    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic short_ev;
        logic long_ev;
        logic held_short;
        logic held_long;
    } lane_flags_t;

endpackage
`default_nettype wire

// File: rtl/four_key_short_long_press_classifier_unit.sv
// Top level of the four-key short/long press classifier.
// The block takes one word per clock cycle when ready and returns a result word for
// each. Four key lanes update their run and total counters and compare the new run
// and old total against the thresholds in the same cycle the word is taken, and the
// merge stage folds the lane results into the event masks and match flags and
// registers them. A new word is taken whenever the result register is empty or its
// word is taken in the same cycle. Threshold writes take effect on the next cycle.
`default_nettype none
module four_key_short_long_press_classifier_unit #(
    parameter int COUNT_BITS = fkpc_pkg::COUNT_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire [fkpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [fkpc_pkg::THR_W-1:0]        cfg_wdata,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [1:0]                        s_op,
    input  wire [fkpc_pkg::NKEYS-1:0]        s_key_pressed,
    input  wire [fkpc_pkg::NKEYS-1:0]        s_key_select,
    input  wire [1:0]                        s_query_mode,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [fkpc_pkg::NKEYS-1:0]       m_short_events,
    output logic [fkpc_pkg::NKEYS-1:0]       m_long_events,
    output logic [fkpc_pkg::NKEYS-1:0]       m_held_short,
    output logic [fkpc_pkg::NKEYS-1:0]       m_held_long,
    output logic                             m_event_match,
    output logic                             m_held_match
);

    logic [fkpc_pkg::THR_W-1:0]                  short_thr_reg;
    logic [fkpc_pkg::THR_W-1:0]                  long_thr_reg;
    logic [fkpc_pkg::THR_W-1:0]                  limit_reg;
    logic                                        accept;
    logic                                        any_pressed;
    fkpc_pkg::op_t                               op;
    fkpc_pkg::lane_flags_t [fkpc_pkg::NKEYS-1:0] flags;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_thr_reg <= fkpc_pkg::SHORT_THR_RST;
            long_thr_reg  <= fkpc_pkg::LONG_THR_RST;
            limit_reg     <= fkpc_pkg::LIMIT_RST;
        end else if (cfg_we) begin
            unique case (fkpc_pkg::cfg_idx_t'(cfg_index))
                fkpc_pkg::REG_SHORT_THR: short_thr_reg <= cfg_wdata;
                fkpc_pkg::REG_LONG_THR:  long_thr_reg  <= cfg_wdata;
                fkpc_pkg::REG_LIMIT:     limit_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_ready     = !m_valid || m_ready;
    assign accept      = s_valid && s_ready;
    assign any_pressed = |s_key_pressed;
    assign op          = fkpc_pkg::op_t'(s_op);

    for (genvar k = 0; k < fkpc_pkg::NKEYS; k++) begin : g_lane
        fkpc_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .accept      (accept),
            .op          (op),
            .pressed     (s_key_pressed[k]),
            .any_pressed (any_pressed),
            .short_thr   (short_thr_reg),
            .long_thr    (long_thr_reg),
            .limit       (limit_reg),
            .flags       (flags[k])
        );
    end

    fkpc_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .op           (op),
        .any_pressed  (any_pressed),
        .key_select   (s_key_select),
        .query_mode   (s_query_mode),
        .flags        (flags),
        .m_ready      (m_ready),
        .out_valid    (m_valid),
        .short_events (m_short_events),
        .long_events  (m_long_events),
        .held_short   (m_held_short),
        .held_long    (m_held_long),
        .event_match  (m_event_match),
        .held_match   (m_held_match)
    );

endmodule
`default_nettype wire

// File: rtl/fkpc_lane.sv
// One key lane: run and total press counters with threshold compares.
`default_nettype none
module fkpc_lane #(
    parameter int COUNT_BITS = fkpc_pkg::COUNT_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          accept,
    input  fkpc_pkg::op_t                op,
    input  wire                          pressed,
    input  wire                          any_pressed,
    input  wire [fkpc_pkg::THR_W-1:0]    short_thr,
    input  wire [fkpc_pkg::THR_W-1:0]    long_thr,
    input  wire [fkpc_pkg::THR_W-1:0]    limit,
    output fkpc_pkg::lane_flags_t        flags
);

    localparam int CMP_W = (COUNT_BITS > fkpc_pkg::THR_W) ? COUNT_BITS : fkpc_pkg::THR_W;

    logic [COUNT_BITS-1:0] run_reg;
    logic [COUNT_BITS-1:0] run_next;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_next;
    logic [CMP_W-1:0]      run_ext;
    logic [CMP_W-1:0]      total_ext;
    logic [CMP_W-1:0]      short_ext;
    logic [CMP_W-1:0]      long_ext;
    logic [CMP_W-1:0]      limit_ext;

    always_comb begin
        run_next   = run_reg;
        total_next = total_reg;
        if (accept) begin
            unique case (op)
                fkpc_pkg::OP_SCAN: begin
                    if (pressed) begin
                        run_next   = (&run_reg) ? run_reg : run_reg + COUNT_BITS'(1);
                        total_next = (&total_reg) ? total_reg : total_reg + COUNT_BITS'(1);
                    end else begin
                        run_next = '0;
                    end
                end
                fkpc_pkg::OP_EVAL: begin
                    if (!any_pressed) begin
                        total_next = '0;
                    end
                end
                default: begin
                    run_next   = run_reg;
                    total_next = total_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= '0;
            total_reg <= '0;
        end else begin
            run_reg   <= run_next;
            total_reg <= total_next;
        end
    end

    assign run_ext   = CMP_W'(run_next);
    assign total_ext = CMP_W'(total_reg);
    assign short_ext = CMP_W'(short_thr);
    assign long_ext  = CMP_W'(long_thr);
    assign limit_ext = CMP_W'(limit);

    assign flags.short_ev   = (total_ext > short_ext) && (total_ext < long_ext);
    assign flags.long_ev    = (total_ext > long_ext) && (total_ext < limit_ext);
    assign flags.held_short = run_ext > short_ext;
    assign flags.held_long  = run_ext > long_ext;

endmodule
`default_nettype wire

// File: rtl/fkpc_merge.sv
// Merge stage: event masks, match flags and the registered result word.
`default_nettype none
module fkpc_merge (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire                                        accept,
    input  fkpc_pkg::op_t                              op,
    input  wire                                        any_pressed,
    input  wire [fkpc_pkg::NKEYS-1:0]                  key_select,
    input  wire [1:0]                                  query_mode,
    input  fkpc_pkg::lane_flags_t [fkpc_pkg::NKEYS-1:0] flags,
    input  wire                                        m_ready,
    output logic                                       out_valid,
    output logic [fkpc_pkg::NKEYS-1:0]                 short_events,
    output logic [fkpc_pkg::NKEYS-1:0]                 long_events,
    output logic [fkpc_pkg::NKEYS-1:0]                 held_short,
    output logic [fkpc_pkg::NKEYS-1:0]                 held_long,
    output logic                                       event_match,
    output logic                                       held_match
);

    logic [fkpc_pkg::NKEYS-1:0] short_mask_reg;
    logic [fkpc_pkg::NKEYS-1:0] short_mask_next;
    logic [fkpc_pkg::NKEYS-1:0] long_mask_reg;
    logic [fkpc_pkg::NKEYS-1:0] long_mask_next;
    logic [fkpc_pkg::NKEYS-1:0] short_ev;
    logic [fkpc_pkg::NKEYS-1:0] long_ev;
    logic [fkpc_pkg::NKEYS-1:0] hs;
    logic [fkpc_pkg::NKEYS-1:0] hl;
    logic                       em;
    logic                       hm;
    logic                       valid_reg;
    logic [fkpc_pkg::NKEYS-1:0] hs_reg;
    logic [fkpc_pkg::NKEYS-1:0] hl_reg;
    logic                       em_reg;
    logic                       hm_reg;

    always_comb begin
        for (int k = 0; k < fkpc_pkg::NKEYS; k++) begin
            short_ev[k] = flags[k].short_ev;
            long_ev[k]  = flags[k].long_ev;
            hs[k]       = flags[k].held_short;
            hl[k]       = flags[k].held_long;
        end
    end

    always_comb begin
        short_mask_next = short_mask_reg;
        long_mask_next  = long_mask_reg;
        if (accept) begin
            unique case (op)
                fkpc_pkg::OP_EVAL: begin
                    if (any_pressed) begin
                        short_mask_next = '0;
                        long_mask_next  = '0;
                    end else begin
                        short_mask_next = short_mask_reg | short_ev;
                        long_mask_next  = long_mask_reg | long_ev;
                    end
                end
                fkpc_pkg::OP_CLEAR: begin
                    if (query_mode[0]) begin
                        short_mask_next = '0;
                    end
                    if (query_mode[1]) begin
                        long_mask_next = '0;
                    end
                end
                default: begin
                    short_mask_next = short_mask_reg;
                    long_mask_next  = long_mask_reg;
                end
            endcase
        end
    end

    always_comb begin
        priority if (query_mode[0]) begin
            em = (short_mask_next == key_select);
            hm = ((hs & key_select) == key_select);
        end else if (query_mode[1]) begin
            em = (long_mask_next == key_select);
            hm = ((hl & key_select) == key_select);
        end else begin
            em = 1'b0;
            hm = (key_select == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_mask_reg <= '0;
            long_mask_reg  <= '0;
            valid_reg      <= 1'b0;
        end else begin
            short_mask_reg <= short_mask_next;
            long_mask_reg  <= long_mask_next;
            if (accept) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hs_reg <= hs;
            hl_reg <= hl;
            em_reg <= em;
            hm_reg <= hm;
        end
    end

    assign out_valid    = valid_reg;
    assign short_events = short_mask_reg;
    assign long_events  = long_mask_reg;
    assign held_short   = hs_reg;
    assign held_long    = hl_reg;
    assign event_match  = em_reg;
    assign held_match   = hm_reg;

endmodule
`default_nettype wire
